// File: sv/send_on_delta_reporter_defines.svh
// ----------------------------------------------------------------------------
// send_on_delta_reporter_defines : assertion macros
// shared clocked assertion forms for the reporter checks
// ----------------------------------------------------------------------------
`ifndef SEND_ON_DELTA_REPORTER_DEFINES_SVH
`define SEND_ON_DELTA_REPORTER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SOD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SOD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/sod_pkg.sv
// ----------------------------------------------------------------------------
// sod_pkg : send-on-delta reporter types and constants
// word formats, channel codes, register codes and register reset values
// ----------------------------------------------------------------------------
package sod_pkg;

    localparam int VALUE_W     = 32;
    localparam int TICK_FIELD_W = 40;
    localparam int THRESH_W    = 31;
    localparam int INTERVAL_W  = 32;
    localparam int NUM_CH      = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    typedef logic [1:0]           t_channel;
    typedef logic [CFG_IDX_W-1:0] t_cfg_index;

    // channel codes
    localparam t_channel CH_TEMP  = 2'd0;
    localparam t_channel CH_HUMID = 2'd1;
    localparam t_channel CH_LUX   = 2'd2;
    localparam t_channel CH_PRESS = 2'd3;

    // register index: msb picks the bank, low bits the channel
    localparam logic CFG_BANK_THRESH   = 1'b0;
    localparam logic CFG_BANK_INTERVAL = 1'b1;

    localparam logic [THRESH_W-1:0] THRESH_RESET [NUM_CH] = '{
        31'd51, 31'd1280, 31'd6400, 31'd5120
    };
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 32'd900000;

    typedef struct packed {
        t_channel                  channel;
        logic signed [VALUE_W-1:0] sample_value;
        logic                      sample_ok;
        logic                      altitude_ok;
        logic [TICK_FIELD_W-1:0]   now_tick;
    } t_in_word;

    typedef struct packed {
        logic                      publish;
        t_channel                  out_channel;
        logic signed [VALUE_W-1:0] out_value;
    } t_out_word;

endpackage

// File: sv/sod_decide.sv
// ----------------------------------------------------------------------------
// sod_decide : publish decision for one sample
// delta and deadline tests, illuminance rules, saturating deadline update
// ----------------------------------------------------------------------------
module sod_decide #(
    parameter int FRAC_BITS = 8,
    parameter int TICK_BITS = 40
) (
    input  sod_pkg::t_in_word                   i_item,
    input  logic signed [sod_pkg::VALUE_W-1:0]  i_last,
    input  logic [TICK_BITS-1:0]                i_deadline,
    input  logic [sod_pkg::THRESH_W-1:0]        i_threshold,
    input  logic [sod_pkg::INTERVAL_W-1:0]      i_interval,
    output logic                                o_publish,
    output logic signed [sod_pkg::VALUE_W-1:0]  o_value,
    output logic [TICK_BITS-1:0]                o_deadline
);
    import sod_pkg::*;

    localparam logic signed [VALUE_W-1:0] LuxOne = VALUE_W'(64'd1 << FRAC_BITS);
    localparam int NowW = (TICK_BITS > TICK_FIELD_W) ? TICK_BITS : TICK_FIELD_W;

    logic [NowW-1:0]             w_now_ext;
    logic [TICK_BITS-1:0]        w_now;
    logic                        w_is_lux;
    logic signed [VALUE_W-1:0]   w_value;
    logic signed [VALUE_W:0]     w_diff;
    logic [VALUE_W:0]            w_mag;
    logic                        w_delta_hit;
    logic                        w_late;
    logic                        w_lux_hit;
    logic [TICK_BITS:0]          w_sum;

    assign w_now_ext = NowW'(i_item.now_tick);
    assign w_now     = w_now_ext[TICK_BITS-1:0];
    assign w_is_lux  = (i_item.channel == CH_LUX);

    // illuminance below one is forced to zero
    assign w_value = (w_is_lux && (i_item.sample_value < LuxOne)) ? '0 : i_item.sample_value;

    // exact 33-bit distance
    assign w_diff      = {w_value[VALUE_W-1], w_value} - {i_last[VALUE_W-1], i_last};
    assign w_mag       = w_diff[VALUE_W] ? (VALUE_W+1)'(-w_diff) : w_diff;
    assign w_delta_hit = (w_mag >= (VALUE_W+1)'(i_threshold));
    assign w_late      = (i_deadline < w_now);

    assign w_lux_hit = w_is_lux &&
                       (((w_value == '0) && (i_last != '0)) ||
                        ((w_value > LuxOne) && (i_last == '0)));

    always_comb begin
        o_publish = i_item.sample_ok && (w_delta_hit || w_late || w_lux_hit);
        if ((i_item.channel == CH_PRESS) && !i_item.altitude_ok) begin
            o_publish = 1'b0;
        end
    end

    assign o_value = o_publish ? w_value : '0;

    // deadline saturates at all ones
    assign w_sum      = {1'b0, w_now} + (TICK_BITS+1)'(i_interval);
    assign o_deadline = w_sum[TICK_BITS] ? '1 : w_sum[TICK_BITS-1:0];

endmodule

// File: sv/send_on_delta_reporter.sv
// ----------------------------------------------------------------------------
// send_on_delta_reporter : four-channel report-on-change filter
// publishes a sample on a large enough change or when the channel's deadline
// has passed; keeps last published value and deadline per channel
// ----------------------------------------------------------------------------
// usage
//   input channel: i_in_valid / o_in_stall / i_in_data, one sample word each;
//     a word is taken at a clock edge with valid high and stall low
//   output channel: o_out_valid / i_out_stall / o_out_data, exactly one result
//     word per sample, in sample order; publish=0 words carry a zero value
//   config channel: i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data;
//     index 0..3 thresholds, 4..7 intervals, in channel order; ready is
//     always high, write only while no sample is in flight
//   a taken sample is held in the input register, then its result word in the
//     result register, from which it leaves
//   throughput: one sample per cycle while the result word is not stalled, set
//     by the single decision stage between the input register and the result register
//   a published sample updates its channel's state in the same edge that loads
//     the result, so the next sample already sees it
//   reset (i_rst_n low, synchronous): both stages empty, last values and
//     deadlines zero, registers back to their defaults
//   a stalled result holds; the input stage keeps accepting until it too is
//     full, then o_in_stall rises
// ----------------------------------------------------------------------------
module send_on_delta_reporter #(
    parameter int FRAC_BITS = 8,
    parameter int TICK_BITS = 40
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // sample words
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  sod_pkg::t_in_word                    i_in_data,
    // result words
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output sod_pkg::t_out_word                   o_out_data,
    // register writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  sod_pkg::t_cfg_index                  i_cfg_index,
    input  logic [sod_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import sod_pkg::*;

    // pipeline stages
    logic                        r_in_vld;
    logic                        n_in_vld;
    t_in_word                    r_in;
    logic                        r_out_vld;
    logic                        n_out_vld;
    t_out_word                   r_out;

    // per-channel registers and state
    logic [THRESH_W-1:0]         r_thresh   [NUM_CH];
    logic [INTERVAL_W-1:0]       r_interval [NUM_CH];
    logic signed [VALUE_W-1:0]   r_last     [NUM_CH];
    logic [TICK_BITS-1:0]        r_deadline [NUM_CH];

    logic                        w_out_load;
    logic                        w_fire;
    logic                        w_publish;
    logic signed [VALUE_W-1:0]   w_value;
    logic [TICK_BITS-1:0]        w_deadline;
    logic                        w_cfg_wr;

    // result register free, or its word leaves this edge
    assign w_out_load = !r_out_vld || !i_out_stall;
    // input stage word moves into the result register
    assign w_fire     = r_in_vld && w_out_load;
    assign o_in_stall = r_in_vld && !w_out_load;

    always_comb begin
        n_in_vld  = r_in_vld;
        n_out_vld = r_out_vld;
        if (!o_in_stall) begin
            n_in_vld = i_in_valid;
        end
        if (w_out_load) begin
            n_out_vld = r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
        if (w_fire) begin
            r_out.publish     <= w_publish;
            r_out.out_channel <= r_in.channel;
            r_out.out_value   <= w_value;
        end
    end

    // decision for the word in the input stage against its channel's state
    sod_decide #(
        .FRAC_BITS (FRAC_BITS),
        .TICK_BITS (TICK_BITS)
    ) u_decide (
        .i_item      (r_in),
        .i_last      (r_last[r_in.channel]),
        .i_deadline  (r_deadline[r_in.channel]),
        .i_threshold (r_thresh[r_in.channel]),
        .i_interval  (r_interval[r_in.channel]),
        .o_publish   (w_publish),
        .o_value     (w_value),
        .o_deadline  (w_deadline)
    );

    // channel state: cleared at reset, otherwise written only when a sample is published
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CH; i++) begin
                r_last[i]     <= '0;
                r_deadline[i] <= '0;
            end
        end else if (w_fire && w_publish) begin
            r_last[r_in.channel]     <= w_value;
            r_deadline[r_in.channel] <= w_deadline;
        end
    end

    // register writes, always accepted
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CH; i++) begin
                r_thresh[i]   <= THRESH_RESET[i];
                r_interval[i] <= INTERVAL_RESET;
            end
        end else if (w_cfg_wr) begin
            case (i_cfg_index[CFG_IDX_W-1])
                CFG_BANK_THRESH: begin
                    r_thresh[i_cfg_index[1:0]] <= i_cfg_data[THRESH_W-1:0];
                end
                CFG_BANK_INTERVAL: begin
                    r_interval[i_cfg_index[1:0]] <= i_cfg_data[INTERVAL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// File: sv/sod_checker.sv
// ----------------------------------------------------------------------------
// sod_checker : port-level checks for the send-on-delta reporter
// watches the top-level ports and is bound to every instance
// ----------------------------------------------------------------------------
`include "send_on_delta_reporter_defines.svh"

module sod_checker #(
    parameter int FRAC_BITS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 o_in_stall,
    input  logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    input  sod_pkg::t_out_word                   o_out_data
);
    import sod_pkg::*;

    localparam logic signed [VALUE_W-1:0] LuxOne = VALUE_W'(64'd1 << FRAC_BITS);

    // a word that is not published reports zero
    `SOD_ASSERT_NOW(a_quiet_zero, i_clk, i_rst_n,
        o_out_valid && !o_out_data.publish, o_out_data.out_value == '0,
        "unpublished word carries a nonzero value")

    // published illuminance is zero or at least one
    `SOD_ASSERT_NOW(a_lux_clamp, i_clk, i_rst_n,
        o_out_valid && o_out_data.publish && (o_out_data.out_channel == CH_LUX),
        (o_out_data.out_value == '0) || (o_out_data.out_value >= LuxOne),
        "published illuminance below one")

    // with the result register empty the input side never stalls
    `SOD_ASSERT_NOW(a_no_false_stall, i_clk, i_rst_n,
        !o_out_valid, !o_in_stall,
        "input stalled while result register empty")

    // a stalled result word holds
    `SOD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data),
        "stalled result word changed")

endmodule

bind send_on_delta_reporter sod_checker #(.FRAC_BITS(FRAC_BITS)) u_sod_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top : send-on-delta reporter testbench
// drives sample words through the reporter under changing register settings
// and idle patterns; a behavioral copy of the report rule, or a hand-typed
// result, gives each expected word, checked field by field in arrival order
// ----------------------------------------------------------------------------
module tb_top;

    import sod_pkg::*;

    localparam int       PHASES      = 8;
    localparam int       PHASE_ITEMS = 216;
    localparam int       SETTLE_CYC  = 4;
    localparam longint   ONE_Q       = longint'(1) << 8;   // 1.0 in Q23.8
    localparam time      RUN_LIMIT   = 5_000_000;          // ns

    // directed table row: sample word plus an optional hand-typed result
    typedef struct {
        t_in_word  word;
        bit        typed;
        t_out_word result;
    } dir_row_t;

    typedef struct {
        bit        typed;
        t_out_word result;
    } typed_result_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    t_in_word           i_in_data = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out_word          o_out_data;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    t_cfg_index         i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // shadow of the block: registers and per-channel history
    logic [THRESH_W-1:0]        thr_reg  [NUM_CH];
    logic [INTERVAL_W-1:0]      ivl_reg  [NUM_CH];
    logic signed [VALUE_W-1:0]  last_pub [NUM_CH];
    logic [TICK_FIELD_W-1:0]    due_tick [NUM_CH];

    t_out_word      report_q [$];    // result words still to arrive, oldest first
    typed_result_t  typed_q  [$];    // hand-typed results, one per word offered
    dir_row_t       dir_rows [$];

    int                      idle_pct  = 0;
    int                      stall_pct = 0;
    int                      err_cnt   = 0;
    logic [TICK_FIELD_W-1:0] base_tick = '0;

    send_on_delta_reporter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #RUN_LIMIT;
        $display("Simulation FAILED");
        $finish;
    end

    // report decision for one accepted sample word; updates the shadow history
    function automatic t_out_word decide_report(input t_in_word w);
        t_out_word                r;
        int                       c;
        logic signed [VALUE_W-1:0] v;
        longint                   gap;
        logic [TICK_FIELD_W:0]    sum;
        logic                     fire;
        c    = int'(w.channel);
        v    = w.sample_value;
        fire = 1'b0;
        r    = '0;
        r.out_channel = w.channel;
        if (w.sample_ok) begin
            // illuminance below one lux reads as dark
            if (w.channel == CH_LUX && longint'(v) < ONE_Q) v = '0;
            // exact distance, no wrap
            gap = longint'(v) - longint'(last_pub[c]);
            if (gap < 0) gap = -gap;
            fire = (gap >= longint'(thr_reg[c])) || (due_tick[c] < w.now_tick);
            if (w.channel == CH_LUX) begin
                if (v == 0 && last_pub[c] != 0) fire = 1'b1;
                if (longint'(v) > ONE_Q && last_pub[c] == 0) fire = 1'b1;
            end
            // pressure needs the altitude read too
            if (w.channel == CH_PRESS && !w.altitude_ok) fire = 1'b0;
            if (fire) begin
                last_pub[c] = v;
                sum = {1'b0, w.now_tick} + (TICK_FIELD_W+1)'(ivl_reg[c]);
                due_tick[c] = sum[TICK_FIELD_W] ? '1 : sum[TICK_FIELD_W-1:0];
            end
        end
        r.publish   = fire;
        r.out_value = fire ? v : '0;
        return r;
    endfunction

    // random sample word aimed at thresholds, deadlines and the lux corners
    function automatic t_in_word gen_word();
        t_in_word w;
        int       c;
        longint   d;
        c = int'($urandom_range(NUM_CH - 1));
        w.channel     = t_channel'(c);
        w.sample_ok   = ($urandom_range(99) < 90);
        w.altitude_ok = ($urandom_range(99) < 85);
        case ($urandom_range(9))
            0: w.sample_value = $urandom;
            1: w.sample_value = VALUE_W'($urandom_range(600)) - VALUE_W'(100);
            2: begin
                case ($urandom_range(3))
                    0: w.sample_value = '0;
                    1: w.sample_value = VALUE_W'(ONE_Q - 1);
                    2: w.sample_value = VALUE_W'(ONE_Q);
                    default: w.sample_value = VALUE_W'(ONE_Q + 1);
                endcase
            end
            default: begin
                // step away from the last published value, near the threshold
                case ($urandom_range(5))
                    0: d = longint'(thr_reg[c]);
                    1: d = longint'(thr_reg[c]) - 1;
                    2: d = longint'(thr_reg[c]) + 1;
                    default: d = longint'($urandom_range(4095));
                endcase
                if ($urandom_range(1)) d = -d;
                w.sample_value = VALUE_W'(longint'(last_pub[c]) + d);
            end
        endcase
        base_tick = base_tick + TICK_FIELD_W'($urandom_range(40));
        case ($urandom_range(7))
            3: w.now_tick = due_tick[c];
            4: w.now_tick = due_tick[c] + 1'b1;
            5: w.now_tick = due_tick[c] - 1'b1;
            6: w.now_tick = TICK_FIELD_W'({$urandom, $urandom});
            7: w.now_tick = '1;
            default: w.now_tick = base_tick;
        endcase
        return w;
    endfunction

    function automatic dir_row_t mk_row(input t_channel ch, input logic [31:0] val,
                                        input int ok, input int alt,
                                        input logic [TICK_FIELD_W-1:0] tick,
                                        input int typed, input int pub,
                                        input logic [31:0] res_val);
        dir_row_t r;
        r.word.channel      = ch;
        r.word.sample_value = val;
        r.word.sample_ok    = ok[0];
        r.word.altitude_ok  = alt[0];
        r.word.now_tick     = tick;
        r.typed             = typed[0];
        r.result.publish    = pub[0];
        r.result.out_channel = ch;
        r.result.out_value  = res_val;
        return r;
    endfunction

    // offer one sample word; valid stays high into the next word unless idling
    task automatic send_word(input t_in_word w, input bit typed, input t_out_word res);
        typed_result_t t;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        t.typed  = typed;
        t.result = res;
        typed_q.push_back(t);
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // stop sending and wait until every expected result word has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (report_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // write all eight registers, thresholds first, in channel order
    task automatic load_settings(input logic [CFG_DATA_W-1:0] thr_w [NUM_CH],
                                 input logic [CFG_DATA_W-1:0] ivl_w [NUM_CH]);
        t_channel              ch;
        logic                  bank;
        logic [CFG_DATA_W-1:0] data;
        for (int k = 0; k < 2 * NUM_CH; k++) begin
            ch   = t_channel'(k % NUM_CH);
            bank = (k < NUM_CH) ? CFG_BANK_THRESH : CFG_BANK_INTERVAL;
            data = (bank == CFG_BANK_THRESH) ? thr_w[ch] : ivl_w[ch];
            i_cfg_valid <= 1'b1;
            i_cfg_index <= {bank, ch};
            i_cfg_data  <= data;
            do @(posedge i_clk); while (!o_cfg_ready);
            // threshold msb is unused
            if (bank == CFG_BANK_THRESH) thr_reg[ch] = data[THRESH_W-1:0];
            else ivl_reg[ch] = data;
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // receiver stall, redrawn every cycle
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // result check first, then prediction for a word taken at this edge
    always @(posedge i_clk) begin
        t_out_word     want;
        t_out_word     calc;
        typed_result_t t;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (report_q.size() == 0) begin
                    err_cnt++;
                    $error("result word with none expected: %p", o_out_data);
                end else begin
                    want = report_q.pop_front();
                    if (o_out_data.publish !== want.publish) begin
                        err_cnt++;
                        $error("publish: expected %0b, actual %0b",
                               want.publish, o_out_data.publish);
                    end
                    if (o_out_data.out_channel !== want.out_channel) begin
                        err_cnt++;
                        $error("out_channel: expected %0d, actual %0d",
                               want.out_channel, o_out_data.out_channel);
                    end
                    if (o_out_data.out_value !== want.out_value) begin
                        err_cnt++;
                        $error("out_value: expected %0d, actual %0d",
                               want.out_value, o_out_data.out_value);
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                // predictor runs on every word so the history stays in step
                calc = decide_report(i_in_data);
                if (typed_q.size() != 0) begin
                    t = typed_q.pop_front();
                    report_q.push_back(t.typed ? t.result : calc);
                end else begin
                    report_q.push_back(calc);
                end
            end
        end
    end

    initial begin
        logic [CFG_DATA_W-1:0] new_thr [NUM_CH];
        logic [CFG_DATA_W-1:0] new_ivl [NUM_CH];
        int                    sel;
        int                    idle_sel;
        // shadow matches the block's reset state
        for (int c = 0; c < NUM_CH; c++) begin
            thr_reg[c]  = THRESH_RESET[c];
            ivl_reg[c]  = INTERVAL_RESET;
            last_pub[c] = '0;
            due_tick[c] = '0;
        end

        // directed words against the reset settings, in order
        // threshold crossing and the strict deadline test on temperature
        dir_rows.push_back(mk_row(CH_TEMP, 32'd100, 1, 0, 40'd0, 1, 1, 32'd100));
        dir_rows.push_back(mk_row(CH_TEMP, 32'd120, 1, 1, 40'd10, 1, 0, 32'd0));
        dir_rows.push_back(mk_row(CH_TEMP, 32'd120, 1, 1, 40'd900000, 1, 0, 32'd0));
        dir_rows.push_back(mk_row(CH_TEMP, 32'd120, 1, 1, 40'd900001, 1, 1, 32'd120));
        // failed read, then value extremes with the full 33-bit distance
        dir_rows.push_back(mk_row(CH_HUMID, 32'h7FFF_FFFF, 0, 1, 40'd5, 1, 0, 32'd0));
        dir_rows.push_back(mk_row(CH_HUMID, 32'h7FFF_FFFF, 1, 1, 40'd0, 1, 1,
                                  32'h7FFF_FFFF));
        dir_rows.push_back(mk_row(CH_HUMID, 32'h8000_0000, 1, 1, 40'd0, 1, 1,
                                  32'h8000_0000));
        // illuminance clamp, rise from dark, drop to dark, exactly one lux
        dir_rows.push_back(mk_row(CH_LUX, 32'd255, 1, 1, 40'd0, 1, 0, 32'd0));
        dir_rows.push_back(mk_row(CH_LUX, 32'd300, 1, 1, 40'd0, 1, 1, 32'd300));
        dir_rows.push_back(mk_row(CH_LUX, 32'hFFFF_FFFB, 1, 1, 40'd0, 1, 1, 32'd0));
        dir_rows.push_back(mk_row(CH_LUX, 32'd256, 1, 1, 40'd0, 1, 0, 32'd0));
        dir_rows.push_back(mk_row(CH_LUX, 32'h8000_0000, 1, 1, 40'd0, 1, 0, 32'd0));
        // altitude failure, then deadline saturation at the top tick
        dir_rows.push_back(mk_row(CH_PRESS, 32'd10000, 1, 0, 40'd0, 1, 0, 32'd0));
        dir_rows.push_back(mk_row(CH_PRESS, 32'd10000, 1, 1, 40'd0, 1, 1, 32'd10000));
        dir_rows.push_back(mk_row(CH_PRESS, 32'd10000, 1, 1, '1, 1, 1, 32'd10000));
        dir_rows.push_back(mk_row(CH_PRESS, 32'd10000, 1, 1, '1, 1, 0, 32'd0));
        dir_rows.push_back(mk_row(CH_PRESS, 32'd10000, 1, 0, '1, 1, 0, 32'd0));
        dir_rows.push_back(mk_row(CH_PRESS, 32'd0, 0, 0, '1, 1, 0, 32'd0));
        // wide swings and threshold equality, left to the predictor
        dir_rows.push_back(mk_row(CH_TEMP, 32'h8000_0000, 1, 1, 40'd1800001, 0, 0, 0));
        dir_rows.push_back(mk_row(CH_TEMP, 32'h7FFF_FFFF, 1, 1, 40'd0, 0, 0, 0));
        dir_rows.push_back(mk_row(CH_TEMP, 32'h7FFF_FFFF, 1, 1, 40'h80_0000_0000,
                                  0, 0, 0));
        dir_rows.push_back(mk_row(CH_HUMID, 32'h8000_0500, 1, 1, 40'd0, 0, 0, 0));
        dir_rows.push_back(mk_row(CH_HUMID, 32'h8000_09FF, 1, 0, 40'd0, 0, 0, 0));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].typed,
                                        dir_rows[i].result);
        drain();

        // random phases: register setting and idle pattern both rotate
        for (int ph = 0; ph < PHASES; ph++) begin
            sel = ph % 4;
            for (int c = 0; c < NUM_CH; c++) begin
                case (sel)
                    0: begin   // zero threshold via the ignored msb, longest interval
                        new_thr[c] = 32'h8000_0000;
                        new_ivl[c] = '1;
                    end
                    1: begin   // largest threshold, zero interval
                        new_thr[c] = '1;
                        new_ivl[c] = '0;
                    end
                    2: begin   // small values so both rules fire often
                        new_thr[c] = $urandom_range(2000);
                        new_ivl[c] = $urandom_range(200);
                    end
                    default: begin
                        new_thr[c] = $urandom;
                        new_ivl[c] = $urandom;
                    end
                endcase
            end
            load_settings(new_thr, new_ivl);

            idle_sel = (ph + ph / 4) % 4;
            case (idle_sel)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 73; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 73; end
                default: begin idle_pct = 18; stall_pct = 18; end
            endcase

            repeat (PHASE_ITEMS) begin
                send_word(gen_word(), 1'b0, '0);
                // now and then hold off until the block is empty
                if ($urandom_range(149) == 0) drain();
            end
            drain();
        end

        if (err_cnt == 0 && report_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
